>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define ASSERT_OFF to drop
// all checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: cond");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_BACK  = 2'd1,
      FUNC_POP_FRONT  = 2'd2,
      FUNC_POP_BACK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  size_half;
      logic [15:0] price;
   } record_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic     en;
      func_type func;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One queue position: a record plus an occupied flag, shifting with neighbors.
// ----------------------------------------------------------------------------
module dq_cell
   import dq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  record_type    push_rec,
   input  record_type    left_data,
   input  logic          left_occ,
   input  record_type    right_data,
   input  logic          right_occ,
   output record_type    data,
   output logic          occ,
   output logic          tail
);

   record_type data_ff, data_in;
   logic       occ_ff, occ_in;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (ctrl.en) begin
         case (ctrl.func)
            FUNC_PUSH_FRONT: begin
               data_in = left_data;
               occ_in  = left_occ;
            end
            FUNC_PUSH_BACK: begin
               // first free slot takes the word
               if (!occ_ff && left_occ) begin
                  data_in = push_rec;
                  occ_in  = 1'b1;
               end
            end
            FUNC_POP_FRONT: begin
               data_in = right_data;
               occ_in  = right_occ;
            end
            FUNC_POP_BACK: begin
               if (occ_ff && !right_occ) begin
                  occ_in = 1'b0;
               end
            end
            default: begin
               occ_in = occ_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign occ  = occ_ff;
   assign tail = occ_ff & ~right_occ;

endmodule

>>> hw/rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of records built as a shifting row of cells.
// ----------------------------------------------------------------------------
//
//   channel | ports           | direction | payload
//   --------+-----------------+-----------+----------------------------------
//   request | req_valid/stall | in        | func, entry_id/size_half/price
//   response| rsp_valid/stall | out       | status, out_*, entry_count
//
// Cycles: one word per cycle unless req_stall is high; each operation ends in
//   the cycle it is accepted; the response appears next cycle from rsp_* regs.
// Reset: synchronous, clears the occupied flags, count and response valid.
// Stalls: req_stall rises only while a response is held and rsp_stall is
//   high; a held response frees its register the cycle it is taken.
//
// Cell 0 holds the front record; occupied cells always form a run starting
// at cell 0. Push front shifts the row toward the back, pop front toward
// the front, push back fills the first free cell and pop back drops the
// last occupied cell (the one-hot tail).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_core
   import dq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_entry_id,
   input  logic [7:0]         req_entry_size_half,
   input  logic [15:0]        req_entry_price,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_out_id,
   output logic [7:0]         rsp_out_size_half,
   output logic [15:0]        rsp_out_price,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   record_type                cell_data [CAPACITY];
   logic       [CAPACITY-1:0] cell_occ;
   logic       [CAPACITY-1:0] cell_tail;

   record_type push_rec;
   record_type back_rec;
   func_type   func;
   logic       accept;
   logic       is_push;
   logic       full;
   logic       empty;
   logic       refused;
   cell_ctrl_type ctrl;

   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff, rsp_status_in;
   record_type         rsp_rec_ff, rsp_rec_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   // ---- request side ----
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign func      = func_type'(req_func);
   assign push_rec  = '{id: req_entry_id, size_half: req_entry_size_half,
                        price: req_entry_price};

   assign full    = cell_occ[CAPACITY-1];
   assign empty   = ~cell_occ[0];
   assign is_push = (func == FUNC_PUSH_FRONT) || (func == FUNC_PUSH_BACK);
   assign refused = is_push ? full : empty;

   assign ctrl.en   = accept & ~refused;
   assign ctrl.func = func;

   // ---- row of cells ----
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      record_type left_data, right_data;
      logic       left_occ, right_occ;

      if (i == 0) begin : g_head
         // the head sees the incoming record as its left neighbor
         assign left_data = push_rec;
         assign left_occ  = 1'b1;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_rec   (push_rec),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .data       (cell_data[i]),
         .occ        (cell_occ[i]),
         .tail       (cell_tail[i])
      );
   end

   // one-hot select of the back record
   always_comb begin
      back_rec = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_rec = back_rec | (cell_data[i] & {$bits(record_type){cell_tail[i]}});
      end
   end

   // ---- fill count and response ----
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_rec_in    = '0;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         FUNC_POP_FRONT: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               count_in   = count_ff - COUNT_W'(1);
               rsp_rec_in = cell_data[0];
            end
         end
         FUNC_POP_BACK: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               count_in   = count_ff - COUNT_W'(1);
               rsp_rec_in = back_rec;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_rec_ff    <= rsp_rec_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_id        = rsp_rec_ff.id;
   assign rsp_out_size_half = rsp_rec_ff.size_half;
   assign rsp_out_price     = rsp_rec_ff.price;
   assign rsp_entry_count   = rsp_count_ff;

   // ---- checks ----
   // occupied cells form one run from the front
   `ASSERT_ALWAYS(a_occ_run, clock, reset, ((cell_occ + 1'b1) & cell_occ) == '0)
   `ASSERT_ALWAYS(a_count_match, clock, reset, count_ff == COUNT_W'($countones(cell_occ)))
   `ASSERT_ALWAYS(a_tail_onehot, clock, reset, $onehot0(cell_tail))
   `ASSERT_NEXT(a_refused_hold, clock, reset, accept && refused, $stable(cell_occ))

endmodule

>>> tb/double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Self-checking bench for the double-ended queue core. A mirror deque tracks
// every accepted request word and queues the response it must produce; the
// response monitor checks each word taken from the core, field by field,
// against the oldest pending response. Directed corner words come first,
// then biased random traffic, a run with no idling, and a long receiver
// hold-off that backs the core up.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;
   import dq_pkg::*;

   localparam int HOLD_CYCLES = 80;

   typedef struct {
      status_type             status;
      record_type             rec;
      logic [COUNT_W-1:0]     count;
   } result_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic [15:0]        req_entry_id = '0;
   logic [7:0]         req_entry_size_half = '0;
   logic [15:0]        req_entry_price = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_out_id;
   logic [7:0]         rsp_out_size_half;
   logic [15:0]        rsp_out_price;
   logic [COUNT_W-1:0] rsp_entry_count;

   // mirror of the deque contents
   record_type      mirror_slots [CAPACITY];
   int              mirror_front = 0;
   int              mirror_back  = 0;
   int              mirror_fill  = 0;
   result_word_type pending_results [$];

   int error_count = 0;
   int idle_pct    = 36;
   int stall_pct   = 36;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   double_ended_queue_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_entry_id        (req_entry_id),
      .req_entry_size_half (req_entry_size_half),
      .req_entry_price     (req_entry_price),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_out_id          (rsp_out_id),
      .rsp_out_size_half   (rsp_out_size_half),
      .rsp_out_price       (rsp_out_price),
      .rsp_entry_count     (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Apply one operation to the mirror and queue the response it must give.
   function automatic void mirror_apply(input func_type f, input record_type rec);
      result_word_type want;
      want.status = STATUS_OK;
      want.rec    = '0;
      case (f)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (mirror_fill >= CAPACITY) begin
               want.status = STATUS_FULL;
            end else if (f == FUNC_PUSH_FRONT) begin
               mirror_front = (mirror_front == 0) ? CAPACITY - 1 : mirror_front - 1;
               mirror_slots[mirror_front] = rec;
               mirror_fill++;
            end else begin
               mirror_slots[mirror_back] = rec;
               mirror_back = (mirror_back + 1) % CAPACITY;
               mirror_fill++;
            end
         end
         default: begin
            if (mirror_fill == 0) begin
               want.status = STATUS_EMPTY;
            end else if (f == FUNC_POP_FRONT) begin
               want.rec = mirror_slots[mirror_front];
               mirror_front = (mirror_front + 1) % CAPACITY;
               mirror_fill--;
            end else begin
               mirror_back = (mirror_back == 0) ? CAPACITY - 1 : mirror_back - 1;
               want.rec = mirror_slots[mirror_back];
               mirror_fill--;
            end
         end
      endcase
      want.count = COUNT_W'(mirror_fill);
      pending_results.push_back(want);
   endfunction

   function automatic record_type random_record();
      record_type rec;
      rec.id        = 16'($urandom_range(16'hFFFF));
      rec.size_half = 8'($urandom_range(8'hFF));
      rec.price     = 16'($urandom_range(16'hFFFF));
      return rec;
   endfunction

   // Push-biased or pop-biased random operation.
   function automatic func_type random_func(input int push_pct);
      bit back_end;
      back_end = 1'($urandom_range(1));
      if ($urandom_range(99) < push_pct) begin
         return back_end ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end
      return back_end ? FUNC_POP_BACK : FUNC_POP_FRONT;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input func_type f, input record_type rec);
      record_type junk;
      while ($urandom_range(99) < idle_pct) begin
         junk                = random_record();
         req_valid           = 1'b0;
         req_func            = 2'($urandom_range(3));
         req_entry_id        = junk.id;
         req_entry_size_half = junk.size_half;
         req_entry_price     = junk.price;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_func            = f;
      req_entry_id        = rec.id;
      req_entry_size_half = rec.size_half;
      req_entry_price     = rec.price;
      do @(posedge clock); while (req_stall);
      mirror_apply(f, rec);
      @(negedge clock);
   endtask

   // Receiver: random stalls, or a counted hold-off on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin : result_check
      result_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            report_error("response word with no request pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_error($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_out_id !== want.rec.id)
               report_error($sformatf("id %h, want %h", rsp_out_id, want.rec.id));
            if (rsp_out_size_half !== want.rec.size_half)
               report_error($sformatf("size %h, want %h",
                                      rsp_out_size_half, want.rec.size_half));
            if (rsp_out_price !== want.rec.price)
               report_error($sformatf("price %h, want %h", rsp_out_price, want.rec.price));
            if (rsp_entry_count !== want.count)
               report_error($sformatf("count %0d, want %0d", rsp_entry_count, want.count));
         end
      end
   end

   // Empty pops, extreme records, wrap of the front index, full refusals.
   task automatic test_directed();
      send_word(FUNC_POP_FRONT, {16'hFFFF, 8'hFF, 16'hFFFF});
      send_word(FUNC_POP_BACK,  {16'hFFFF, 8'hFF, 16'hFFFF});
      send_word(FUNC_PUSH_FRONT, {16'hFFFF, 8'hFF, 16'hFFFF});
      send_word(FUNC_PUSH_BACK,  {16'h0000, 8'h00, 16'h0000});
      send_word(FUNC_POP_BACK,  {16'hA5A5, 8'h5A, 16'h5A5A});
      send_word(FUNC_POP_FRONT, {16'h0000, 8'h00, 16'h0000});
      for (int i = 0; i < CAPACITY; i++) begin
         send_word(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                   {16'(16'h0100 + i), 8'(8'hF0 + i), 16'(16'hA000 + i)});
      end
      send_word(FUNC_PUSH_FRONT, {16'h1234, 8'h56, 16'h789A});
      send_word(FUNC_PUSH_BACK,  {16'hFFFF, 8'hFF, 16'hFFFF});
      send_word(FUNC_POP_FRONT,  {16'h0000, 8'h00, 16'h0000});
   endtask

   // Bursts with a push or pop bias so the queue swings between full and empty.
   task automatic test_random_mix(input int bursts);
      int push_pct;
      int burst_len;
      for (int b = 0; b < bursts; b++) begin
         case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         burst_len = $urandom_range(20, 60);
         repeat (burst_len) send_word(random_func(push_pct), random_record());
      end
   endtask

   task automatic test_no_idle(input int words);
      idle_pct  = 0;
      stall_pct = 0;
      repeat (words) send_word(random_func(50), random_record());
      idle_pct  = 36;
      stall_pct = 36;
   endtask

   // Receiver holds off while the sender keeps offering, so req_stall rises.
   task automatic test_backpressure(input int words);
      idle_pct     = 0;
      hold_request = 1'b1;
      repeat (words) send_word(random_func(60), random_record());
      idle_pct     = 36;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix(38);
      test_no_idle(200);
      test_backpressure(60);
      test_random_mix(3);
      test_backpressure(40);

      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> double_ended_queue_core.f
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_cell.sv
hw/rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_test.sv
